// ===== rtl/command_packet_framer_unit_macros.svh =====
// Assertion macros shared by the framer checker.
`ifndef COMMAND_PACKET_FRAMER_UNIT_MACROS_SVH
`define COMMAND_PACKET_FRAMER_UNIT_MACROS_SVH

// Concurrent check on clk, disabled while rst_n is low.
`define CPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define CPF_ASSERT_IMPL(lbl, ante, cons, msg) \
    `CPF_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/cpf_pkg.sv =====
package cpf_pkg;

    // Frame geometry
    localparam logic [7:0] MAX_PAYLOAD     = 8'd239;
    localparam logic [7:0] FRAME_OVERHEAD  = 8'h10;
    localparam logic [7:0] MODULE_OVERHEAD = 8'h06;
    localparam logic [7:0] FRAME_TO_MODULE = FRAME_OVERHEAD - MODULE_OVERHEAD;

    // Sum of the seven prefix bytes
    localparam logic [15:0] MAGIC_SUM = 16'h0041 + 16'h0044 + 16'h0041 + 16'h004d
                                      + 16'h0001 + 16'h0000 + 16'h0001;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODULE_ID = 2'd0;
    localparam logic [1:0] CFG_DIRECTION = 2'd1;
    localparam logic [1:0] CFG_COMMAND   = 2'd2;

    // Byte positions within a frame burst
    localparam logic [3:0] STEP_FIRST      = 4'd0;
    localparam logic [3:0] STEP_FLEN       = 4'd7;
    localparam logic [3:0] STEP_HSUM_LO    = 4'd8;
    localparam logic [3:0] STEP_HSUM_HI    = 4'd9;
    localparam logic [3:0] STEP_MODULE_ID  = 4'd10;
    localparam logic [3:0] STEP_MODULE_LEN = 4'd11;
    localparam logic [3:0] STEP_DIRECTION  = 4'd12;
    localparam logic [3:0] STEP_CMD_DATA   = 4'd13;
    localparam logic [3:0] STEP_SUM_LO     = 4'd14;
    localparam logic [3:0] STEP_SUM_HI     = 4'd15;

    // Work handed from the frame control to the byte emitter
    typedef struct packed {
        logic [7:0]  flen;
        logic [7:0]  byte13;
        logic [15:0] sum;
        logic [3:0]  first_step;
        logic [3:0]  last_step;
    } cpf_desc_t;

    // Header fields taken from configuration
    typedef struct packed {
        logic [7:0] module_id;
        logic [7:0] direction_code;
    } cpf_cfg_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h41;
            3'd1:    b = 8'h44;
            3'd2:    b = 8'h41;
            3'd3:    b = 8'h4d;
            3'd4:    b = 8'h01;
            3'd5:    b = 8'h00;
            3'd6:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/cpf_frame_ctl.sv =====
module cpf_frame_ctl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                action,
    input  logic [7:0]          payload_byte,
    input  logic [7:0]          payload_length,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output logic                desc_load,
    output cpf_pkg::cpf_desc_t  desc,
    output cpf_pkg::cpf_cfg_t   cfg
);

    logic        frame_open_reg,      frame_open_next;
    logic [7:0]  bytes_remaining_reg, bytes_remaining_next;
    logic [15:0] running_sum_reg,     running_sum_next;
    logic [7:0]  current_length_reg,  current_length_next;
    logic [7:0]  module_id_reg;
    logic [7:0]  direction_code_reg;
    logic [7:0]  command_code_reg;

    logic [7:0]  plen_sat;
    logic [7:0]  start_flen;
    logic [7:0]  start_mlen;
    logic [15:0] start_sum;
    logic [7:0]  rem_dec;
    logic [15:0] pay_sum;

    // Clamp the length and build the start-of-frame sums
    always_comb
    begin
        plen_sat   = (payload_length > cpf_pkg::MAX_PAYLOAD) ? cpf_pkg::MAX_PAYLOAD
                                                             : payload_length;
        start_flen = cpf_pkg::FRAME_OVERHEAD + plen_sat;
        start_mlen = cpf_pkg::MODULE_OVERHEAD + plen_sat;
        start_sum  = {8'h00, module_id_reg} + {8'h00, start_mlen}
                   + {8'h00, direction_code_reg} + {8'h00, command_code_reg};
        rem_dec    = (bytes_remaining_reg != 8'd0) ? bytes_remaining_reg - 8'd1 : 8'd0;
        pay_sum    = running_sum_reg + {8'h00, payload_byte};
    end

    // Advance frame state and describe the burst for the emitter
    always_comb
    begin
        frame_open_next      = frame_open_reg;
        bytes_remaining_next = bytes_remaining_reg;
        running_sum_next     = running_sum_reg;
        current_length_next  = current_length_reg;
        desc_load            = 1'b0;
        desc.flen            = cpf_pkg::FRAME_OVERHEAD + current_length_reg;
        desc.byte13          = payload_byte;
        desc.sum             = pay_sum;
        desc.first_step      = cpf_pkg::STEP_CMD_DATA;
        desc.last_step       = cpf_pkg::STEP_CMD_DATA;
        if (take)
        begin
            if (!action)
            begin
                desc_load            = 1'b1;
                current_length_next  = plen_sat;
                running_sum_next     = start_sum;
                frame_open_next      = (plen_sat != 8'd0);
                bytes_remaining_next = plen_sat;
                desc.flen            = start_flen;
                desc.byte13          = command_code_reg;
                desc.sum             = start_sum;
                desc.first_step      = cpf_pkg::STEP_FIRST;
                desc.last_step       = (plen_sat == 8'd0) ? cpf_pkg::STEP_SUM_HI
                                                          : cpf_pkg::STEP_CMD_DATA;
            end
            else if (frame_open_reg)
            begin
                desc_load            = 1'b1;
                running_sum_next     = pay_sum;
                bytes_remaining_next = rem_dec;
                if (rem_dec == 8'd0)
                begin
                    frame_open_next = 1'b0;
                    desc.last_step  = cpf_pkg::STEP_SUM_HI;
                end
            end
        end
    end

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg      <= 1'b0;
            bytes_remaining_reg <= 8'd0;
            running_sum_reg     <= 16'd0;
            current_length_reg  <= 8'd0;
        end
        else
        begin
            frame_open_reg      <= frame_open_next;
            bytes_remaining_reg <= bytes_remaining_next;
            running_sum_reg     <= running_sum_next;
            current_length_reg  <= current_length_next;
        end
    end

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_id_reg      <= 8'd0;
            direction_code_reg <= 8'd0;
            command_code_reg   <= 8'd2;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cpf_pkg::CFG_MODULE_ID: module_id_reg      <= cfg_data;
                cpf_pkg::CFG_DIRECTION: direction_code_reg <= cfg_data;
                cpf_pkg::CFG_COMMAND:   command_code_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.module_id      = module_id_reg;
    assign cfg.direction_code = direction_code_reg;

endmodule

// ===== rtl/cpf_byte_emit.sv =====
module cpf_byte_emit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                desc_load,
    input  cpf_pkg::cpf_desc_t  desc,
    input  cpf_pkg::cpf_cfg_t   cfg,
    output logic                can_take,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                last_of_packet,
    output logic [7:0]          frame_length
);

    cpf_pkg::cpf_desc_t desc_reg;
    logic        busy_reg;
    logic [3:0]  step_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        last_reg;
    logic [7:0]  flen_reg;

    logic        advance;
    logic        emit;
    logic        finishing;
    logic [15:0] hsum;
    logic [7:0]  sel_byte;

    assign advance   = !out_valid_reg || out_ready;
    assign emit      = busy_reg && advance;
    assign finishing = emit && (step_reg == desc_reg.last_step);
    assign can_take  = !busy_reg || finishing;
    assign hsum      = cpf_pkg::MAGIC_SUM + {8'h00, desc_reg.flen};

    // Pick the byte for the current step
    always_comb
    begin
        unique case (step_reg)
            cpf_pkg::STEP_FLEN:       sel_byte = desc_reg.flen;
            cpf_pkg::STEP_HSUM_LO:    sel_byte = hsum[7:0];
            cpf_pkg::STEP_HSUM_HI:    sel_byte = hsum[15:8];
            cpf_pkg::STEP_MODULE_ID:  sel_byte = cfg.module_id;
            cpf_pkg::STEP_MODULE_LEN: sel_byte = desc_reg.flen - cpf_pkg::FRAME_TO_MODULE;
            cpf_pkg::STEP_DIRECTION:  sel_byte = cfg.direction_code;
            cpf_pkg::STEP_CMD_DATA:   sel_byte = desc_reg.byte13;
            cpf_pkg::STEP_SUM_LO:     sel_byte = desc_reg.sum[7:0];
            cpf_pkg::STEP_SUM_HI:     sel_byte = desc_reg.sum[15:8];
            default:                  sel_byte = cpf_pkg::magic_byte(step_reg[2:0]);
        endcase
    end

    // Load a new burst or advance through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= cpf_pkg::STEP_FIRST;
        end
        else if (desc_load)
        begin
            busy_reg <= 1'b1;
            step_reg <= desc.first_step;
        end
        else if (finishing)
        begin
            busy_reg <= 1'b0;
        end
        else if (emit)
        begin
            step_reg <= step_reg + 4'd1;
        end
    end

    // Hold the burst payload
    always_ff @(posedge clk)
    begin
        if (desc_load)
        begin
            desc_reg <= desc;
        end
    end

    // Output register: fill on emit, drop after transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= sel_byte;
            last_reg     <= (step_reg == cpf_pkg::STEP_SUM_HI);
            flen_reg     <= desc_reg.flen;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign last_of_packet = last_reg;
    assign frame_length   = flen_reg;

endmodule

// ===== rtl/command_packet_framer_unit.sv =====
// Command packet framer. Each input transfer is either a frame start (action 0, with a
// payload length clamped to 239) or a payload byte (action 1); the block returns the
// framed byte stream one byte per output transfer, together with the frame's total
// length and a flag on the final checksum byte. A start yields 14 bytes (16 when the
// length is zero), a payload byte yields one byte (three for the last byte of a frame),
// and a payload byte with no frame open yields nothing. Output is one byte per cycle
// while out_ready holds, set by the single output register: an item is accepted in the
// cycle its predecessor's final byte moves into that register, so payload bytes of an
// open frame flow back to back; a start holds input until its 14 (or 16) bytes are in.
// An item is held in desc_reg, then its first byte in the output register. Configuration
// writes are always accepted and are meant to be made while no frame bytes are pending.
module command_packet_framer_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] payload_byte,
    input  logic [7:0] payload_length,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_packet,
    output logic [7:0] frame_length,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cpf_pkg::cpf_desc_t desc;
    cpf_pkg::cpf_cfg_t  cfg;
    logic               desc_load;
    logic               can_take;

    assign in_ready  = can_take;
    assign cfg_ready = 1'b1;

    cpf_frame_ctl u_ctl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (in_valid && can_take),
        .action         (action),
        .payload_byte   (payload_byte),
        .payload_length (payload_length),
        .cfg_write      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .desc_load      (desc_load),
        .desc           (desc),
        .cfg            (cfg)
    );

    cpf_byte_emit u_emit
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .desc_load      (desc_load),
        .desc           (desc),
        .cfg            (cfg),
        .can_take       (can_take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .last_of_packet (last_of_packet),
        .frame_length   (frame_length)
    );

endmodule

// ===== rtl/cpf_checker.sv =====
`include "command_packet_framer_unit_macros.svh"

module cpf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       action,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_packet,
    input logic [7:0] frame_length
);

    // A stalled output transfer keeps its byte
    `CPF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte), "output byte changed while stalled")

    // Every emitted byte belongs to a frame of at least the header and checksum
    `CPF_ASSERT_IMPL(a_flen_min, out_valid, frame_length >= 8'd16, "frame length below overhead")

    // An accepted start is followed by valid output from the output register
    `CPF_ASSERT(a_start_out, in_valid && in_ready && !action |=> ##1 out_valid, "start produced no output")

    // The closing byte of a frame never comes straight from a start acceptance cycle
    `CPF_ASSERT(a_last_gap, in_valid && in_ready && !action |=> !(out_valid && last_of_packet && $rose(out_valid)), "checksum byte too early")

endmodule

bind command_packet_framer_unit cpf_checker u_cpf_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last_of_packet (last_of_packet),
    .frame_length   (frame_length)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam logic       ACT_START     = 1'b0;
    localparam logic       ACT_PAYLOAD   = 1'b1;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;
    localparam logic [55:0] PREFIX_BYTES = 56'h41_44_41_4d_01_00_01;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         PRINT_LIMIT   = 40;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic [7:0] flen;
    } frame_byte_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       action;
    logic [7:0] payload_byte;
    logic [7:0] payload_length;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       last_of_packet;
    logic [7:0] frame_length;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // Expected framed bytes, oldest first
    frame_byte_t frame_bytes_q[$];
    frame_byte_t want;

    // Framer state as seen by the testbench
    logic        frame_is_open;
    logic [7:0]  bytes_left;
    logic [15:0] data_sum;
    logic [7:0]  open_len;
    logic [7:0]  reg_module_id;
    logic [7:0]  reg_direction;
    logic [7:0]  reg_command;

    logic idling_on;
    int   errors;
    int   cycles;
    int   items_taken;
    int   items_dropped;
    int   bytes_seen;
    int   frames_closed;
    int   frames_aborted;
    int   settings_used;

    command_packet_framer_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .payload_byte   (payload_byte),
        .payload_length (payload_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .last_of_packet (last_of_packet),
        .frame_length   (frame_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d bytes pending", cycles,
                     frame_bytes_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want_v);
        if (errors < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got %0h, want %0h", $realtime, what, got, want_v);
        errors++;
    endtask

    task automatic queue_byte(input logic [7:0] value, input logic last, input logic [7:0] flen);
        frame_byte_t b;
        b.value = value;
        b.last  = last;
        b.flen  = flen;
        frame_bytes_q.push_back(b);
    endtask

    // Append both checksum bytes and close the frame
    task automatic queue_data_sum(input logic [7:0] flen);
        queue_byte(data_sum[7:0], 1'b0, flen);
        queue_byte(data_sum[15:8], 1'b1, flen);
        frame_is_open = 1'b0;
        bytes_left    = 8'd0;
    endtask

    // Compute the bytes that one accepted input transfer produces
    task automatic predict_frame_bytes(input logic act, input logic [7:0] pbyte,
                                       input logic [7:0] plen);
        logic [7:0]  len;
        logic [7:0]  flen;
        logic [7:0]  mlen;
        logic [7:0]  pb;
        logic [15:0] hsum;
        int          i;
        if (act == ACT_START)
        begin
            if (frame_is_open)
                frames_aborted++;
            len      = (plen > cpf_pkg::MAX_PAYLOAD) ? cpf_pkg::MAX_PAYLOAD : plen;
            open_len = len;
            flen     = len + cpf_pkg::FRAME_OVERHEAD;
            mlen     = len + cpf_pkg::MODULE_OVERHEAD;
            hsum     = {8'h00, flen};
            for (i = 0; i < 7; i++)
            begin
                pb   = PREFIX_BYTES[55 - 8 * i -: 8];
                hsum = hsum + {8'h00, pb};
                queue_byte(pb, 1'b0, flen);
            end
            queue_byte(flen, 1'b0, flen);
            queue_byte(hsum[7:0], 1'b0, flen);
            queue_byte(hsum[15:8], 1'b0, flen);
            queue_byte(reg_module_id, 1'b0, flen);
            queue_byte(mlen, 1'b0, flen);
            queue_byte(reg_direction, 1'b0, flen);
            queue_byte(reg_command, 1'b0, flen);
            data_sum = {8'h00, reg_module_id} + {8'h00, mlen} + {8'h00, reg_direction}
                     + {8'h00, reg_command};
            frame_is_open = 1'b1;
            bytes_left    = len;
            items_taken++;
            if (len == 8'd0)
                queue_data_sum(flen);
        end
        else if (!frame_is_open)
        begin
            // Drop a byte that has no frame to belong to
            items_dropped++;
        end
        else
        begin
            flen = open_len + cpf_pkg::FRAME_OVERHEAD;
            queue_byte(pbyte, 1'b0, flen);
            data_sum = data_sum + {8'h00, pbyte};
            if (bytes_left > 8'd0)
                bytes_left = bytes_left - 8'd1;
            items_taken++;
            if (bytes_left == 8'd0)
                queue_data_sum(flen);
        end
    endtask

    // Check each output transfer against the oldest expected byte
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            bytes_seen++;
            if (frame_bytes_q.size() == 0)
                report_mismatch("byte with nothing pending", out_byte, 0);
            else
            begin
                want = frame_bytes_q.pop_front();
                if (out_byte !== want.value)
                    report_mismatch("out_byte", out_byte, want.value);
                if (last_of_packet !== want.last)
                    report_mismatch("last_of_packet", last_of_packet, want.last);
                if (frame_length !== want.flen)
                    report_mismatch("frame_length", frame_length, want.flen);
                if (want.last)
                    frames_closed++;
            end
        end
    end

    // Stall the output side in random bursts
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(posedge clk);
        end
    end

    // Send one input transfer, with an optional idle burst ahead of it
    task automatic send_item(input logic act, input logic [7:0] pbyte, input logic [7:0] plen);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        payload_byte   <= pbyte;
        payload_length <= plen;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_frame_bytes(act, pbyte, plen);
    endtask

    task automatic send_start(input logic [7:0] len);
        send_item(ACT_START, 8'($urandom), len);
    endtask

    task automatic send_payload(input logic [7:0] value);
        send_item(ACT_PAYLOAD, value, 8'($urandom));
    endtask

    task automatic close_open_frame();
        while (frame_is_open)
            send_payload(8'($urandom));
    endtask

    // Hold the input until every expected byte is out, then let the pipe settle
    task automatic drain_frames();
        in_valid <= 1'b0;
        while (frame_bytes_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Keep cfg_valid high; the caller drops it after the last write
    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            cpf_pkg::CFG_MODULE_ID: reg_module_id = value;
            cpf_pkg::CFG_DIRECTION: reg_direction = value;
            cpf_pkg::CFG_COMMAND:   reg_command   = value;
            default:       ;
        endcase
    endtask

    task automatic program_registers(input logic [7:0] mid, input logic [7:0] dir,
                                     input logic [7:0] cmd);
        write_register(cpf_pkg::CFG_MODULE_ID, mid);
        write_register(cpf_pkg::CFG_DIRECTION, dir);
        write_register(cpf_pkg::CFG_COMMAND, cmd);
        cfg_valid <= 1'b0;
        settings_used++;
        @(posedge clk);
    endtask

    task automatic test_default_registers();
        send_start(8'd0);
        send_start(8'd2);
        send_payload(8'h00);
        send_payload(8'hff);
    endtask

    task automatic test_orphan_payload();
        drain_frames();
        send_payload(8'ha5);
        drain_frames();
    endtask

    task automatic test_register_extremes();
        program_registers(8'hff, 8'hff, 8'hff);
        send_start(8'd1);
        send_payload(8'hff);
        drain_frames();
        program_registers(8'h00, 8'h00, 8'h00);
        // A write to the spare index must not touch any register
        write_register(CFG_UNUSED, 8'h5a);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_start(8'd0);
    endtask

    task automatic test_length_extremes();
        send_start(cpf_pkg::MAX_PAYLOAD);
        send_payload(8'h3c);
        send_start(8'd255);
        send_payload(8'h00);
        send_payload(8'hff);
        send_start(8'd240);
        send_start(8'd1);
        send_payload(8'h81);
    endtask

    task automatic test_abort_open_frame();
        send_start(8'd5);
        send_payload(8'h11);
        send_payload(8'h22);
        send_start(8'd2);
        send_payload(8'h33);
        send_payload(8'h44);
    endtask

    // Mostly well-formed frames with random content, plus aborts and stray bytes
    task automatic test_random_frames(input int quota);
        int         first;
        int         n_pay;
        int         r;
        int         k;
        logic [7:0] len;
        first = items_taken;
        while (items_taken - first < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send_payload(8'($urandom));
            else if (r < 7 && idling_on)
                drain_frames();
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = 8'($urandom_range(0, 8));
                else if (r < 95)
                    len = 8'($urandom_range(9, 40));
                else
                    len = 8'($urandom_range(240, 255));
                n_pay = (len > cpf_pkg::MAX_PAYLOAD) ? $urandom_range(0, 6) : int'(len);
                if (n_pay > 0 && $urandom_range(0, 9) == 0)
                    n_pay = $urandom_range(0, n_pay - 1);
                send_start(len);
                for (k = 0; k < n_pay; k++)
                    send_payload(8'($urandom));
            end
        end
        close_open_frame();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        action         <= 1'b0;
        payload_byte   <= 8'h00;
        payload_length <= 8'h00;
        out_ready      <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= cpf_pkg::CFG_MODULE_ID;
        cfg_data       <= 8'h00;
        frame_is_open  = 1'b0;
        bytes_left     = 8'd0;
        data_sum       = 16'd0;
        open_len       = 8'd0;
        reg_module_id  = 8'h00;
        reg_direction  = 8'h00;
        reg_command    = 8'h02;
        idling_on      = 1'b1;
        errors         = 0;
        items_taken    = 0;
        items_dropped  = 0;
        bytes_seen     = 0;
        frames_closed  = 0;
        frames_aborted = 0;
        settings_used  = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        test_default_registers();
        test_orphan_payload();
        test_register_extremes();
        test_length_extremes();
        test_abort_open_frame();
        close_open_frame();

        drain_frames();
        program_registers(8'($urandom), 8'($urandom), 8'($urandom));
        test_random_frames(25);

        // Run back to back with no idling on either side
        drain_frames();
        program_registers(8'hff, 8'h00, 8'hff);
        idling_on = 1'b0;
        test_random_frames(25);
        idling_on = 1'b1;

        drain_frames();
        program_registers(8'($urandom), 8'($urandom), 8'($urandom));
        test_random_frames(25);

        drain_frames();
        program_registers(8'h00, 8'hff, 8'h00);
        idling_on = 1'b0;
        test_random_frames(25);

        drain_frames();
        $display("Covered %0d input items (%0d dropped), %0d output bytes, %0d frames closed",
                 items_taken, items_dropped, bytes_seen, frames_closed);
        $display("Aborted frames: %0d, register settings: %0d, mismatches: %0d",
                 frames_aborted, settings_used, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
